[hdl/erm_pkg.sv]
// Shared constants, types and arithmetic helpers for the Euler rotation matrix block.
package erm_pkg;

  localparam int AngleW   = 16;
  localparam int EntryW   = 16;
  localparam int AngleFrac = 12;
  localparam int PhaseW   = 32;
  localparam int PhProdW  = 64;
  localparam int QW       = 31;  // unsigned Q30 up to 1.0
  localparam int SW       = 32;  // signed Q30 up to +/-1.0
  localparam int SumW     = 34;
  localparam int QsLat    = 6;

  localparam logic [30:0] PhaseScale = 31'd683565276;
  localparam logic [30:0] OneQ30     = 31'h4000_0000;

  localparam logic [30:0] QsCoef [5] = '{
    31'd1686629713, 31'd693598669, 31'd85569306, 31'd5026995, 31'd172272
  };

  localparam int EntShift = 30 - (EntryW - 2);
  localparam logic [SumW-1:0] EntRnd =
      (EntShift > 0) ? (SumW'(1) << (EntShift - 1)) : '0;
  localparam logic [SumW-1:0] EntLim = SumW'(1) << (EntryW - 2);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic signed [SW-1:0]     q30_t;
  typedef logic signed [EntryW-1:0] entry_t;

  // Q30 product, rounded half away from zero.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic neg;
    p   = a * b;
    neg = p[63];
    m   = neg ? (64'd0 - 64'(p)) : 64'(p);
    m   = (m + 64'h2000_0000) >> 30;
    return neg ? q30_t'(64'd0 - m) : q30_t'(m);
  endfunction

  // Round a Q30 sum to the entry format and saturate to +/-1.0.
  function automatic entry_t to_entry(input logic signed [SumW-1:0] v);
    logic [SumW-1:0] m;
    logic neg;
    neg = v[SumW-1];
    m   = neg ? (SumW'(0) - SumW'(v)) : SumW'(v);
    m   = (m + EntRnd) >> EntShift;
    if (m > EntLim) begin
      m = EntLim;
    end
    return neg ? entry_t'(SumW'(0) - m) : entry_t'(m);
  endfunction

endpackage

[hdl/euler_rotation_matrix_top.sv]
// Top level of the Euler-angle to 3x3 rotation matrix pipeline.
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ---------------------------------------
//  command   in         start_i, busy_o       angle_x_i, angle_y_i, angle_z_i (Q3.12)
//  result    out        done_o (1-cycle)      elem_0_0_o .. elem_2_2_o (Q1.14)
//
//  An item is taken at every edge with start_i high; busy_o stays low, so one
//  item can enter each cycle. Its matrix appears for one cycle with done_o high,
//  after the sine/cosine units (phase scaling, six multiplier stages of the
//  polynomial, quadrant fold) and then the products, second-level products and
//  round/saturate.
//  Reset clears only the valid bits; the receiver cannot stall, so nothing waits.
module euler_rotation_matrix_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [erm_pkg::AngleW-1:0] angle_x_i,
  input  logic [erm_pkg::AngleW-1:0] angle_y_i,
  input  logic [erm_pkg::AngleW-1:0] angle_z_i,
  output logic                       done_o,
  output logic [erm_pkg::EntryW-1:0] elem_0_0_o,
  output logic [erm_pkg::EntryW-1:0] elem_0_1_o,
  output logic [erm_pkg::EntryW-1:0] elem_0_2_o,
  output logic [erm_pkg::EntryW-1:0] elem_1_0_o,
  output logic [erm_pkg::EntryW-1:0] elem_1_1_o,
  output logic [erm_pkg::EntryW-1:0] elem_1_2_o,
  output logic [erm_pkg::EntryW-1:0] elem_2_0_o,
  output logic [erm_pkg::EntryW-1:0] elem_2_1_o,
  output logic [erm_pkg::EntryW-1:0] elem_2_2_o
);
  import erm_pkg::*;

  logic   accept;
  logic   vld_x, vld_y, vld_z;
  q30_t   sx, cx, sy, cy, sz, cz;
  entry_t elem [9];

  // Never hold off the command side: the pipeline drains on its own.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  erm_sincos u_sc_x (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_x_i),
    .valid_o(vld_x), .sin_o(sx), .cos_o(cx)
  );

  // The y and z units run in lockstep with x; their valids are combined with it.
  erm_sincos u_sc_y (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_y_i),
    .valid_o(vld_y), .sin_o(sy), .cos_o(cy)
  );

  erm_sincos u_sc_z (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(angle_z_i),
    .valid_o(vld_z), .sin_o(sz), .cos_o(cz)
  );

  erm_matrix u_mat (
    .clk_i, .rst_ni,
    .valid_i(vld_x & vld_y & vld_z),
    .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy), .sz_i(sz), .cz_i(cz),
    .valid_o(done_o), .elem_o(elem)
  );

  // Entries leave in storage order.
  assign elem_0_0_o = elem[0];
  assign elem_0_1_o = elem[1];
  assign elem_0_2_o = elem[2];
  assign elem_1_0_o = elem[3];
  assign elem_1_1_o = elem[4];
  assign elem_1_2_o = elem[5];
  assign elem_2_0_o = elem[6];
  assign elem_2_1_o = elem[7];
  assign elem_2_2_o = elem[8];

endmodule

[hdl/erm_qsine.sv]
// Pipelined quarter-wave sine polynomial, Q30 in and out.
module erm_qsine (
  input  logic                 clk_i,
  input  logic [erm_pkg::QW-1:0] x_i,
  output logic [erm_pkg::QW-1:0] s_o
);
  import erm_pkg::*;

  logic [QW-1:0] x_q  [5];
  logic [QW-1:0] x2_q [4];
  logic [QW-1:0] t_q  [4];
  logic [QW-1:0] s_q;
  logic [61:0]   sq_prod;
  logic [61:0]   h_prod [4];
  logic [61:0]   f_prod;
  logic [31:0]   f_sh;

  assign sq_prod = 62'(x_i) * 62'(x_i);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h_prod[k] = 62'((k == 0) ? QsCoef[4] : t_q[(k == 0) ? 0 : k - 1]) * 62'(x2_q[k]);
    end
  end

  assign f_prod = 62'(t_q[3]) * 62'(x_q[4]);
  assign f_sh   = f_prod[61:30];

  always_ff @(posedge clk_i) begin
    x_q[0]  <= x_i;
    x2_q[0] <= sq_prod[60:30];
    for (int k = 0; k < 4; k++) begin
      t_q[k]   <= QsCoef[3-k] - h_prod[k][60:30];
      x_q[k+1] <= x_q[k];
      if (k < 3) begin
        x2_q[k+1] <= x2_q[k];
      end
    end
    s_q <= (f_sh > 32'(OneQ30)) ? OneQ30 : f_sh[QW-1:0];
  end

  assign s_o = s_q;

endmodule

[hdl/erm_sincos.sv]
// Sine and cosine of one angle: phase scaling, two quarter-wave units, quadrant fold.
module erm_sincos (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [erm_pkg::AngleW-1:0] angle_i,
  output logic                       valid_o,
  output erm_pkg::q30_t              sin_o,
  output erm_pkg::q30_t              cos_o
);
  import erm_pkg::*;

  logic signed [PhProdW-1:0] a_ext;
  logic signed [PhProdW-1:0] ph_prod;
  logic [PhaseW-1:0] ph_q;
  logic              ph_vld_q;
  logic [QW-1:0]     r;
  logic [QW-1:0]     rc;
  logic [QW-1:0]     sr;
  logic [QW-1:0]     sc;
  logic [1:0]        quad_q [QsLat];
  logic [QsLat-1:0]  vld_q;
  q30_t              sin_d, cos_d, sin_q, cos_q;
  logic              out_vld_q;

  assign a_ext   = PhProdW'($signed(angle_i));
  assign ph_prod = a_ext * $signed(PhProdW'(PhaseScale));

  always_ff @(posedge clk_i) begin
    ph_q <= ph_prod[AngleFrac +: PhaseW];
  end

  assign r  = {1'b0, ph_q[29:0]};
  assign rc = OneQ30 - r;

  erm_qsine u_qs_r (.clk_i(clk_i), .x_i(r),  .s_o(sr));
  erm_qsine u_qs_c (.clk_i(clk_i), .x_i(rc), .s_o(sc));

  always_ff @(posedge clk_i) begin
    quad_q[0] <= ph_q[31:30];
    for (int k = 1; k < QsLat; k++) begin
      quad_q[k] <= quad_q[k-1];
    end
  end

  always_comb begin
    unique case (quad_e'(quad_q[QsLat-1]))
      QUAD_0: begin
        sin_d = q30_t'(sr);
        cos_d = q30_t'(sc);
      end
      QUAD_1: begin
        sin_d = q30_t'(sc);
        cos_d = -q30_t'(sr);
      end
      QUAD_2: begin
        sin_d = -q30_t'(sr);
        cos_d = -q30_t'(sc);
      end
      default: begin
        sin_d = -q30_t'(sc);
        cos_d = q30_t'(sr);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_vld_q  <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      ph_vld_q  <= valid_i;
      vld_q     <= {vld_q[QsLat-2:0], ph_vld_q};
      out_vld_q <= vld_q[QsLat-1];
    end
  end

  assign valid_o = out_vld_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

[hdl/erm_matrix.sv]
// Three-stage product, sum and saturation pipeline for the nine matrix entries.
module erm_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  erm_pkg::q30_t   sx_i,
  input  erm_pkg::q30_t   cx_i,
  input  erm_pkg::q30_t   sy_i,
  input  erm_pkg::q30_t   cy_i,
  input  erm_pkg::q30_t   sz_i,
  input  erm_pkg::q30_t   cz_i,
  output logic            valid_o,
  output erm_pkg::entry_t elem_o [9]
);
  import erm_pkg::*;

  // stage A
  q30_t a_cycz_q, a_cysz_q, a_cxsz_q, a_cxcz_q, a_sxcy_q, a_sxsz_q, a_sxcz_q, a_cxcy_q;
  q30_t a_sxsy_q, a_cxsy_q, a_sy_q, a_sz_q, a_cz_q;
  // stage B
  q30_t b_cycz_q, b_cysz_q, b_cxsz_q, b_cxcz_q, b_sxcy_q, b_sxsz_q, b_sxcz_q, b_cxcy_q;
  q30_t b_sy_q, b_sxsycz_q, b_sxsysz_q, b_cxsycz_q, b_cxsysz_q;
  entry_t elem_q [9];
  logic a_vld_q, b_vld_q, c_vld_q;

  always_ff @(posedge clk_i) begin
    a_cycz_q <= mulq(cy_i, cz_i);
    a_cysz_q <= mulq(cy_i, sz_i);
    a_cxsz_q <= mulq(cx_i, sz_i);
    a_cxcz_q <= mulq(cx_i, cz_i);
    a_sxcy_q <= mulq(sx_i, cy_i);
    a_sxsz_q <= mulq(sx_i, sz_i);
    a_sxcz_q <= mulq(sx_i, cz_i);
    a_cxcy_q <= mulq(cx_i, cy_i);
    a_sxsy_q <= mulq(sx_i, sy_i);
    a_cxsy_q <= mulq(cx_i, sy_i);
    a_sy_q   <= sy_i;
    a_sz_q   <= sz_i;
    a_cz_q   <= cz_i;
  end

  always_ff @(posedge clk_i) begin
    b_cycz_q   <= a_cycz_q;
    b_cysz_q   <= a_cysz_q;
    b_cxsz_q   <= a_cxsz_q;
    b_cxcz_q   <= a_cxcz_q;
    b_sxcy_q   <= a_sxcy_q;
    b_sxsz_q   <= a_sxsz_q;
    b_sxcz_q   <= a_sxcz_q;
    b_cxcy_q   <= a_cxcy_q;
    b_sy_q     <= a_sy_q;
    b_sxsycz_q <= mulq(a_sxsy_q, a_cz_q);
    b_sxsysz_q <= mulq(a_sxsy_q, a_sz_q);
    b_cxsycz_q <= mulq(a_cxsy_q, a_cz_q);
    b_cxsysz_q <= mulq(a_cxsy_q, a_sz_q);
  end

  always_ff @(posedge clk_i) begin
    elem_q[0] <= to_entry(SumW'(b_cycz_q));
    elem_q[1] <= to_entry(SumW'(b_cysz_q));
    elem_q[2] <= to_entry(-SumW'(b_sy_q));
    elem_q[3] <= to_entry(SumW'(b_sxsycz_q) - SumW'(b_cxsz_q));
    elem_q[4] <= to_entry(SumW'(b_cxcz_q) + SumW'(b_sxsysz_q));
    elem_q[5] <= to_entry(SumW'(b_sxcy_q));
    elem_q[6] <= to_entry(SumW'(b_sxsz_q) + SumW'(b_cxsycz_q));
    elem_q[7] <= to_entry(SumW'(b_cxsysz_q) - SumW'(b_sxcz_q));
    elem_q[8] <= to_entry(SumW'(b_cxcy_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  assign valid_o = c_vld_q;
  assign elem_o  = elem_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Euler-angle rotation matrix pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import erm_pkg::*;

  localparam int LatCycles = 11;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [EntryW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [AngleW-1:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic done_o;
  logic [EntryW-1:0] elem_0_0_o, elem_0_1_o, elem_0_2_o, elem_1_0_o, elem_1_1_o;
  logic [EntryW-1:0] elem_1_2_o, elem_2_0_o, elem_2_1_o, elem_2_2_o;

  matrix_t matrix_q[$];
  int mismatch_cnt = 0;
  int error_cnt = 0;
  int items_sent = 0;
  int matrices_seen = 0;
  int cycle_cnt = 0;
  int gap_pct = 0;

  euler_rotation_matrix_top u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** euler_rotation_matrix_top: FAILED **");
      $finish;
    end
  end

  // Round a value half away from zero by 2^s.
  function automatic longint rnd_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    if (s > 0) m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return rnd_shift(a * b, 30);
  endfunction

  // Quarter-wave sine polynomial in Q30, clamped to 1.0.
  function automatic longint quarter_wave(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd172272;
    t = 64'd5026995 - ((t * x2) >> 30);
    t = 64'd85569306 - ((t * x2) >> 30);
    t = 64'd693598669 - ((t * x2) >> 30);
    t = 64'd1686629713 - ((t * x2) >> 30);
    t = (t * x) >> 30;
    if (t > 64'h4000_0000) t = 64'h4000_0000;
    return longint'(t);
  endfunction

  task automatic angle_sin_cos(input logic [AngleW-1:0] ang, output longint s,
                               output longint c);
    longint a;
    longint unsigned ph, r;
    longint sr, sc;
    quad_e q;
    a = longint'($signed(ang));
    ph = ((unsigned'(a) * 64'd683565276) >> AngleFrac) & 64'hFFFF_FFFF;
    q = quad_e'(ph[31:30]);
    r = ph & 64'h3FFF_FFFF;
    sr = quarter_wave(r);
    sc = quarter_wave(64'h4000_0000 - r);
    case (q)
      QUAD_0: begin s = sr; c = sc; end
      QUAD_1: begin s = sc; c = -sr; end
      QUAD_2: begin s = -sr; c = -sc; end
      default: begin s = -sc; c = sr; end
    endcase
  endtask

  function automatic logic [EntryW-1:0] sat_entry(longint v);
    longint lim, e;
    lim = 64'sd1 <<< (EntryW - 2);
    e = rnd_shift(v, 30 - (EntryW - 2));
    if (e > lim) e = lim;
    if (e < -lim) e = -lim;
    return e[EntryW-1:0];
  endfunction

  task automatic predict_matrix(input logic [AngleW-1:0] ax, ay, az, output matrix_t m);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    angle_sin_cos(az, sz, cz);
    sxsy = prod_q30(sx, sy);
    cxsy = prod_q30(cx, sy);
    m.e00 = sat_entry(prod_q30(cy, cz));
    m.e01 = sat_entry(prod_q30(cy, sz));
    m.e02 = sat_entry(-sy);
    m.e10 = sat_entry(-prod_q30(cx, sz) + prod_q30(sxsy, cz));
    m.e11 = sat_entry(prod_q30(cx, cz) + prod_q30(sxsy, sz));
    m.e12 = sat_entry(prod_q30(sx, cy));
    m.e20 = sat_entry(prod_q30(sx, sz) + prod_q30(cxsy, cz));
    m.e21 = sat_entry(-prod_q30(sx, cz) + prod_q30(cxsy, sz));
    m.e22 = sat_entry(prod_q30(cx, cy));
  endtask

  // Drive one item at the falling edge, hold until it is taken.
  task automatic send_angles(input logic [AngleW-1:0] ax, ay, az);
    matrix_t m;
    while ($urandom_range(99, 0) < gap_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    do @(posedge clk_i); while (busy_o);
    predict_matrix(ax, ay, az, m);
    matrix_q.push_back(m);
    items_sent++;
    // Leave start high; the next call or the drain lowers it.
  endtask

  task automatic release_start();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic drain_all();
    release_start();
    while (matrix_q.size() != 0) @(negedge clk_i);
  endtask

  // Compare each strobed matrix with the oldest prediction.
  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && done_o) begin
      got = {elem_0_0_o, elem_0_1_o, elem_0_2_o, elem_1_0_o, elem_1_1_o,
             elem_1_2_o, elem_2_0_o, elem_2_1_o, elem_2_2_o};
      matrices_seen++;
      if (matrix_q.size() == 0) begin
        error_cnt++;
        $display("unexpected matrix %h", got);
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[16*i +: 16] !== want[16*i +: 16]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("entry %0d of matrix %0d: expected %0d got %0d", 8 - i,
                       matrices_seen, $signed(want[16*i +: 16]),
                       $signed(got[16*i +: 16]));
          end
        end
      end
    end
  end

  // Extremes, zero, quarter turns and sign-bit patterns.
  task automatic test_directed();
    logic [AngleW-1:0] pts [10];
    pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
            16'h1922, 16'h3244, 16'hE6DE, 16'h6487, 16'h5555};
    for (int i = 0; i < 10; i++) send_angles(pts[i], pts[i], pts[i]);
    for (int i = 0; i < 10; i++) send_angles(pts[i], pts[(i + 3) % 10], pts[(i + 7) % 10]);
    // Pitch near +90 degrees drives the mixed sums toward saturation.
    send_angles(16'h1922, 16'h1922, 16'h0C91);
    send_angles(16'hE6DE, 16'h1922, 16'hF36F);
    drain_all();
  endtask

  task automatic test_random(input int count, input int pct);
    logic [AngleW-1:0] ax, ay, az;
    gap_pct = pct;
    for (int i = 0; i < count; i++) begin
      ax = AngleW'($urandom());
      ay = AngleW'($urandom());
      az = AngleW'($urandom());
      // Roll and pitch mostly in the principal range, some full-width patterns; yaw always full-width.
      if ($urandom_range(3, 0) != 0) begin
        ax = 16'($signed($urandom_range(25736, 0)) - 12868);
        ay = 16'($signed($urandom_range(25736, 0)) - 12868);
      end
      send_angles(ax, ay, az);
    end
    drain_all();
    gap_pct = 0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(180, 19);
    test_random(180, 63);
    test_random(190, 0);
    repeat (LatCycles + 5) @(negedge clk_i);
    $display("sent %0d angle triples, checked %0d matrices (sender gaps 19/63/0 pct)",
             items_sent, matrices_seen);
    if (error_cnt == 0 && mismatch_cnt == 0 && matrix_q.size() == 0) begin
      $display("** euler_rotation_matrix_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d other errors, %0d missing", mismatch_cnt,
               error_cnt, matrix_q.size());
      $display("** euler_rotation_matrix_top: FAILED **");
    end
    $finish;
  end

endmodule
